// ===== src/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Types, codes and the drive unit mapping shared by the block buffer cache
// policy modules.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam logic [2:0] FUNC_GET   = 3'd0;
    localparam logic [2:0] FUNC_PUT   = 3'd1;
    localparam logic [2:0] FUNC_DIRTY = 3'd2;
    localparam logic [2:0] FUNC_FAIL  = 3'd3;
    localparam logic [2:0] FUNC_SYNC  = 3'd4;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_WBACK  = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NODEV   = 2'd1;
    localparam logic [1:0] ST_NOFREE  = 2'd2;
    localparam logic [1:0] ST_PUTINV  = 2'd3;

    localparam logic [1:0] DEV_FLOPPY = 2'd0;
    localparam logic [1:0] DEV_DISK   = 2'd1;
    localparam logic [1:0] DEV_LOOP   = 2'd2;

    localparam logic [1:0] CFG_LOOP_BASE    = 2'd0;
    localparam logic [1:0] CFG_FLOPPY_UNITS = 2'd1;
    localparam logic [1:0] CFG_DISK_UNITS   = 2'd2;
    localparam logic [1:0] CFG_LOOP_UNITS   = 2'd3;

    localparam logic [7:0] RST_LOOP_BASE    = 8'd240;
    localparam logic [7:0] RST_FLOPPY_UNITS = 8'd2;
    localparam logic [7:0] RST_DISK_UNITS   = 8'd1;
    localparam logic [7:0] RST_LOOP_UNITS   = 8'd0;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  drive_unit;
        logic [31:0] block_number;
        logic        overwrite;
        logic [2:0]  slot_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [2:0]  slot_out;
        logic [1:0]  device;
        logic [7:0]  device_unit;
        logic [31:0] command_block;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] loop_base;
        logic [7:0] floppy_units;
        logic [7:0] disk_units;
        logic [7:0] loop_units;
    } t_cfg;

    typedef struct packed {
        logic       present;
        logic [1:0] device;
        logic [7:0] unit;
    } t_map;

    function automatic t_map map_unit(input logic [7:0] u, input t_cfg cfg);
        t_map       m;
        logic [7:0] n;
        n = 8'd0;
        if (u >= cfg.loop_base) begin
            n         = u - cfg.loop_base;
            m.device  = DEV_LOOP;
            m.present = (n < cfg.loop_units);
        end else if (u[7]) begin
            n         = {1'b0, u[6:0]};
            m.device  = DEV_DISK;
            m.present = (n < cfg.disk_units);
        end else begin
            n         = u;
            m.device  = DEV_FLOPPY;
            m.present = (n < cfg.floppy_units);
        end
        m.unit = n;
        return m;
    endfunction

endpackage

// ===== src/bbc_tag_ram.sv =====
// ----------------------------------------------------------------------------
// bbc_tag_ram
// Tag store: unit and block number of each slot, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module bbc_tag_ram #(
    parameter int SLOTS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(SLOTS)-1:0] i_waddr,
    input  logic [7:0]               i_wunit,
    input  logic [31:0]              i_wblock,
    input  logic [$clog2(SLOTS)-1:0] i_raddr,
    output logic [7:0]               o_runit,
    output logic [31:0]              o_rblock
);
    logic [39:0] r_mem [SLOTS];
    logic [39:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wunit, i_wblock};
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_runit  = r_rdata[39:32];
    assign o_rblock = r_rdata[31:0];
endmodule

// ===== src/block_buffer_cache_policy.sv =====
// ----------------------------------------------------------------------------
// block_buffer_cache_policy
// Tag and replacement control for a ring of disk block cache slots.
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   request  | i_in_valid, o_in_stall, i_in_data    | in
//   result   | o_out_valid, i_out_stall, o_out_data | out
//   config   | i_cfg_we, i_cfg_index, i_cfg_data    | in
//
// One request at a time. Get walks the ring one slot per cycle through the
// tag RAM read port. Results leave through a single output register; a
// stalled output holds the sequencer. Reset is synchronous and needs no
// clearing pass.
// ----------------------------------------------------------------------------
module block_buffer_cache_policy #(
    parameter int SLOTS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bbc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bbc_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);
    import bbc_pkg::*;

    localparam int SW  = $clog2(SLOTS);
    localparam int SLW = (SW > 3) ? SW : 3;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_VICTIM, S_READ, S_SYNC, S_DONE
    } t_state;

    t_state      r_state, n_state;
    t_cfg        r_cfg;
    t_in_item    r_req, n_req;
    t_map        r_map, n_map;
    logic [SLOTS-1:0] r_valid, n_valid, r_busy, n_busy, r_dirty, n_dirty;
    logic [SW-1:0] r_head, n_head, r_scan, n_scan, r_cnt, n_cnt;
    logic [SW-1:0] r_victim, n_victim, r_slot, n_slot;
    logic        r_found, n_found;
    logic [1:0]  r_status, n_status;
    t_out_item   r_out, n_out;
    logic        r_out_valid, n_out_valid;

    logic [7:0]  w_runit;
    logic [31:0] w_rblock;
    logic        w_we;
    t_map        w_in_map, w_tag_map;
    logic [SLW-1:0] w_sl_ext, w_slot_ext, w_scan_ext;
    logic [SW-1:0]  w_sl;
    logic        w_sl_ok, w_out_free, w_hit, w_accept;

    bbc_tag_ram #(.SLOTS(SLOTS)) u_tag_ram (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (r_scan),
        .i_wunit  (r_req.drive_unit),
        .i_wblock (r_req.block_number),
        .i_raddr  (n_scan),
        .o_runit  (w_runit),
        .o_rblock (w_rblock)
    );

    assign w_in_map   = map_unit(i_in_data.drive_unit, r_cfg);
    assign w_tag_map  = map_unit(w_runit, r_cfg);
    assign w_sl_ext   = SLW'(i_in_data.slot_in);
    assign w_sl       = w_sl_ext[SW-1:0];
    assign w_sl_ok    = (32'(w_sl_ext) < 32'(SLOTS));
    assign w_slot_ext = SLW'(r_slot);
    assign w_scan_ext = SLW'(r_scan);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_hit      = r_valid[r_scan] && (w_runit == r_req.drive_unit)
                        && (w_rblock == r_req.block_number);
    assign w_we       = (r_state == S_VICTIM) && w_out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_map       = r_map;
        n_valid     = r_valid;
        n_busy      = r_busy;
        n_dirty     = r_dirty;
        n_head      = r_head;
        n_scan      = r_scan;
        n_cnt       = r_cnt;
        n_victim    = r_victim;
        n_slot      = r_slot;
        n_found     = r_found;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req   = i_in_data;
                    n_map   = w_in_map;
                    n_slot  = '0;
                    n_cnt   = '0;
                    n_found = 1'b0;
                    case (i_in_data.func)
                        FUNC_GET: begin
                            if (!w_in_map.present) begin
                                n_status = ST_NODEV;
                                n_state  = S_DONE;
                            end else begin
                                n_scan  = r_head;
                                n_state = S_SEARCH;
                            end
                        end
                        FUNC_PUT: begin
                            if (!w_sl_ok || !r_busy[w_sl]) begin
                                n_status = ST_PUTINV;
                            end else begin
                                n_status     = ST_OK;
                                n_busy[w_sl] = 1'b0;
                            end
                            n_state = S_DONE;
                        end
                        FUNC_DIRTY: begin
                            if (w_sl_ok && r_valid[w_sl]) begin
                                n_dirty[w_sl] = 1'b1;
                            end
                        end
                        FUNC_FAIL: begin
                            if (w_sl_ok) begin
                                n_valid[w_sl] = 1'b0;
                                n_busy[w_sl]  = 1'b0;
                                n_dirty[w_sl] = 1'b0;
                            end
                        end
                        FUNC_SYNC: begin
                            n_scan   = r_head;
                            n_status = ST_OK;
                            n_state  = S_SYNC;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (w_hit) begin
                    n_busy[r_scan] = 1'b1;
                    n_slot         = r_scan;
                    n_status       = ST_OK;
                    n_state        = S_DONE;
                end else begin
                    if (!r_found && !r_busy[r_scan]) begin
                        n_found  = 1'b1;
                        n_victim = r_scan;
                    end
                    if (r_cnt == LAST_SLOT) begin
                        if (n_found) begin
                            n_scan  = n_victim;
                            n_state = S_VICTIM;
                        end else begin
                            n_status = ST_NOFREE;
                            n_state  = S_DONE;
                        end
                    end else begin
                        n_cnt  = r_cnt + SW'(1);
                        n_scan = (r_scan == LAST_SLOT) ? '0 : r_scan + SW'(1);
                    end
                end
            end
            S_VICTIM: begin
                if (w_out_free) begin
                    if (r_valid[r_scan] && r_dirty[r_scan] && w_tag_map.present) begin
                        n_out.kind          = KIND_WBACK;
                        n_out.status        = ST_OK;
                        n_out.slot_out      = w_scan_ext[2:0];
                        n_out.device        = w_tag_map.device;
                        n_out.device_unit   = w_tag_map.unit;
                        n_out.command_block = w_rblock;
                        n_out.last          = 1'b0;
                        n_out_valid         = 1'b1;
                    end
                    n_valid[r_scan] = 1'b1;
                    n_busy[r_scan]  = 1'b1;
                    n_dirty[r_scan] = 1'b0;
                    n_head   = (r_scan == LAST_SLOT) ? '0 : r_scan + SW'(1);
                    n_status = ST_OK;
                    n_state  = r_req.overwrite ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                if (w_out_free) begin
                    n_out.kind          = KIND_READ;
                    n_out.status        = ST_OK;
                    n_out.slot_out      = w_slot_ext[2:0];
                    n_out.device        = r_map.device;
                    n_out.device_unit   = r_map.unit;
                    n_out.command_block = r_req.block_number;
                    n_out.last          = 1'b0;
                    n_out_valid         = 1'b1;
                    n_state             = S_DONE;
                end
            end
            S_SYNC: begin
                if (!(r_valid[r_scan] && r_dirty[r_scan])) begin
                    n_cnt  = r_cnt + SW'(1);
                    n_scan = (r_scan == LAST_SLOT) ? '0 : r_scan + SW'(1);
                end else if (w_out_free) begin
                    n_dirty[r_scan] = 1'b0;
                    if (w_tag_map.present) begin
                        n_out.kind          = KIND_WBACK;
                        n_out.status        = ST_OK;
                        n_out.slot_out      = w_scan_ext[2:0];
                        n_out.device        = w_tag_map.device;
                        n_out.device_unit   = w_tag_map.unit;
                        n_out.command_block = w_rblock;
                        n_out.last          = 1'b0;
                        n_out_valid         = 1'b1;
                    end
                    n_cnt  = r_cnt + SW'(1);
                    n_scan = (r_scan == LAST_SLOT) ? '0 : r_scan + SW'(1);
                end
                if (r_cnt == LAST_SLOT && n_cnt != r_cnt) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out.kind          = KIND_STATUS;
                    n_out.status        = r_status;
                    n_out.slot_out      = w_slot_ext[2:0];
                    n_out.device        = DEV_FLOPPY;
                    n_out.device_unit   = 8'd0;
                    n_out.command_block = 32'd0;
                    n_out.last          = 1'b1;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // victim slot is reported by the read and final status
        if (r_state == S_VICTIM && w_out_free) begin
            n_slot = r_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= '0;
            r_busy        <= '0;
            r_dirty       <= '0;
            r_head        <= '0;
            r_scan        <= '0;
            r_cnt         <= '0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cfg.loop_base    <= RST_LOOP_BASE;
            r_cfg.floppy_units <= RST_FLOPPY_UNITS;
            r_cfg.disk_units   <= RST_DISK_UNITS;
            r_cfg.loop_units   <= RST_LOOP_UNITS;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_busy      <= n_busy;
            r_dirty     <= n_dirty;
            r_head      <= n_head;
            r_scan      <= n_scan;
            r_cnt       <= n_cnt;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LOOP_BASE:    r_cfg.loop_base    <= i_cfg_data;
                    CFG_FLOPPY_UNITS: r_cfg.floppy_units <= i_cfg_data;
                    CFG_DISK_UNITS:   r_cfg.disk_units   <= i_cfg_data;
                    CFG_LOOP_UNITS:   r_cfg.loop_units   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_req    <= n_req;
        r_map    <= n_map;
        r_victim <= n_victim;
        r_slot   <= n_slot;
        r_status <= n_status;
        r_out    <= n_out;
    end
endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for block_buffer_cache_policy. A queue-fed driver sends
// request transactions with random gaps; a monitor with random stalls compares
// every result transaction, field by field, against a cycle-free predictor of
// the slot ring, its tags and the drive unit mapping. The run moves through
// several register settings, extremes included, and holds the result side
// off long enough once to back the block up into its request port.
// ----------------------------------------------------------------------------
module tb;
    import bbc_pkg::*;

    localparam int SLOTS  = 8;
    localparam int SETTLE = SLOTS + 12;

    localparam logic [2:0] FUNC_RSVD5 = 3'd5;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;
    localparam logic [1:0] DEV_NONE   = 2'd0;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_in_item   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_data;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = CFG_LOOP_BASE;
    logic [7:0] cfg_data  = 8'd0;
    logic       hold_off  = 1'b0;

    // predictor state
    logic [7:0]  loop_first;
    logic [7:0]  floppy_count;
    logic [7:0]  disk_count;
    logic [7:0]  loop_count;
    logic [7:0]  line_unit   [SLOTS];
    logic [31:0] line_block  [SLOTS];
    logic        line_valid  [SLOTS];
    logic        line_pinned [SLOTS];
    logic        line_dirty  [SLOTS];
    int          search_start;

    t_in_item  pending_reqs[$];
    t_out_item expected_replies[$];

    logic [7:0]  unit_pool  [4];
    logic [31:0] block_pool [4];

    int n_queued   = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_settings = 1;
    int n_hits     = 0;
    int n_misses   = 0;
    int n_reads    = 0;
    int n_wbacks   = 0;
    int n_refused  = 0;
    int in_gap     = 0;
    int in_quiet   = 0;
    int out_gap    = 0;
    int out_quiet  = 0;

    block_buffer_cache_policy #(
        .SLOTS(SLOTS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic resolve_drive(input logic [7:0] u, output logic [1:0] dev,
                                           output logic [7:0] du);
        if (u >= loop_first) begin
            dev = DEV_LOOP;
            du  = u - loop_first;
            return du < loop_count;
        end
        if (u[7]) begin
            dev = DEV_DISK;
            du  = {1'b0, u[6:0]};
            return du < disk_count;
        end
        dev = DEV_FLOPPY;
        du  = u;
        return du < floppy_count;
    endfunction

    task automatic push_reply(input logic [1:0] kind, input logic [1:0] status,
                              input int slot, input logic [1:0] dev, input logic [7:0] du,
                              input logic [31:0] blk, input logic last);
        t_out_item r;
        r.kind          = kind;
        r.status        = status;
        r.slot_out      = slot[2:0];
        r.device        = dev;
        r.device_unit   = du;
        r.command_block = blk;
        r.last          = last;
        expected_replies.push_back(r);
    endtask

    task automatic flush_line(input int s);
        logic [1:0] dev;
        logic [7:0] du;
        if (line_valid[s] && line_dirty[s]) begin
            line_dirty[s] = 1'b0;
            if (resolve_drive(line_unit[s], dev, du)) begin
                push_reply(KIND_WBACK, ST_OK, s, dev, du, line_block[s], 1'b0);
                n_wbacks++;
            end
        end
    endtask

    task automatic predict_reply(input t_in_item req);
        logic [1:0] dev;
        logic [7:0] du;
        int         s;
        int         victim;
        logic       found;
        logic       hit;
        found  = 1'b0;
        hit    = 1'b0;
        victim = 0;
        case (req.func)
            FUNC_GET: begin
                if (!resolve_drive(req.drive_unit, dev, du)) begin
                    push_reply(KIND_STATUS, ST_NODEV, 0, DEV_NONE, 8'd0, 32'd0, 1'b1);
                    n_refused++;
                end else begin
                    for (int i = 0; i < SLOTS; i++) begin
                        s = (search_start + i) % SLOTS;
                        if (!hit && line_valid[s] && line_unit[s] == req.drive_unit
                                && line_block[s] == req.block_number) begin
                            hit            = 1'b1;
                            line_pinned[s] = 1'b1;
                            push_reply(KIND_STATUS, ST_OK, s, DEV_NONE, 8'd0, 32'd0, 1'b1);
                            n_hits++;
                        end else if (!hit && !found && !line_pinned[s]) begin
                            found  = 1'b1;
                            victim = s;
                        end
                    end
                    if (!hit && !found) begin
                        push_reply(KIND_STATUS, ST_NOFREE, 0, DEV_NONE, 8'd0, 32'd0, 1'b1);
                        n_refused++;
                    end else if (!hit) begin
                        flush_line(victim);
                        line_unit[victim]   = req.drive_unit;
                        line_block[victim]  = req.block_number;
                        line_valid[victim]  = 1'b1;
                        line_dirty[victim]  = 1'b0;
                        line_pinned[victim] = 1'b1;
                        search_start        = (victim + 1) % SLOTS;
                        if (!req.overwrite) begin
                            push_reply(KIND_READ, ST_OK, victim, dev, du, req.block_number,
                                       1'b0);
                            n_reads++;
                        end
                        push_reply(KIND_STATUS, ST_OK, victim, DEV_NONE, 8'd0, 32'd0, 1'b1);
                        n_misses++;
                    end
                end
            end
            FUNC_PUT: begin
                if (!line_pinned[req.slot_in]) begin
                    push_reply(KIND_STATUS, ST_PUTINV, 0, DEV_NONE, 8'd0, 32'd0, 1'b1);
                end else begin
                    line_pinned[req.slot_in] = 1'b0;
                    push_reply(KIND_STATUS, ST_OK, 0, DEV_NONE, 8'd0, 32'd0, 1'b1);
                end
            end
            FUNC_DIRTY: begin
                if (line_valid[req.slot_in])
                    line_dirty[req.slot_in] = 1'b1;
            end
            FUNC_FAIL: begin
                line_valid[req.slot_in]  = 1'b0;
                line_pinned[req.slot_in] = 1'b0;
                line_dirty[req.slot_in]  = 1'b0;
            end
            FUNC_SYNC: begin
                for (int i = 0; i < SLOTS; i++)
                    flush_line((search_start + i) % SLOTS);
                push_reply(KIND_STATUS, ST_OK, 0, DEV_NONE, 8'd0, 32'd0, 1'b1);
            end
            default: ;
        endcase
    endtask

    task automatic log_error(input string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            log_error($sformatf("result %0d field %s: expected %h, got %h",
                                n_checked, name, want, got));
    endtask

    task automatic compare_reply(input t_out_item got);
        t_out_item want;
        if (expected_replies.size() == 0) begin
            log_error($sformatf("result %h arrived with none expected", got));
            return;
        end
        want = expected_replies.pop_front();
        n_checked++;
        check_field("kind", 32'(want.kind), 32'(got.kind));
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("slot_out", 32'(want.slot_out), 32'(got.slot_out));
        check_field("device", 32'(want.device), 32'(got.device));
        check_field("device_unit", 32'(want.device_unit), 32'(got.device_unit));
        check_field("command_block", want.command_block, got.command_block);
        check_field("last", 32'(want.last), 32'(got.last));
    endtask

    // driver: one request transaction at a time from pending_reqs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_reply(in_data);
                n_accepted++;
                if (in_quiet > 0) begin
                    in_quiet--;
                    in_gap = 0;
                end else begin
                    if ($urandom_range(0, 39) == 0)
                        in_quiet = $urandom_range(10, 30);
                    in_gap = idle_len();
                end
            end
            if (!in_valid || !in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    in_data  <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks result transactions, stalls at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall)
                compare_reply(out_data);
            if (out_gap > 0)
                out_gap--;
            else if (out_quiet > 0)
                out_quiet--;
            else if ($urandom_range(0, 59) == 0)
                out_quiet = $urandom_range(20, 60);
            else if ($urandom_range(0, 2) == 0)
                out_gap = idle_len();
            out_stall <= hold_off || (out_gap > 0);
        end
    end

    // long result-side hold-off while requests keep coming
    initial begin
        while (n_accepted < 90)
            @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #4_000_000;
        $display("tb: errors");
        $finish;
    end

    function automatic logic [7:0] any_unit();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 3));
            1:       return 8'h80 | 8'($urandom_range(0, 3));
            2:       return loop_first + 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_get(input logic [7:0] unit, input logic [31:0] blk, input logic ow);
        t_in_item r;
        r.func         = FUNC_GET;
        r.drive_unit   = unit;
        r.block_number = blk;
        r.overwrite    = ow;
        r.slot_in      = 3'($urandom_range(0, 7));
        pending_reqs.push_back(r);
        n_queued++;
    endtask

    task automatic queue_op(input logic [2:0] func, input logic [2:0] slot);
        t_in_item r;
        r.func         = func;
        r.drive_unit   = 8'($urandom_range(0, 255));
        r.block_number = $urandom();
        r.overwrite    = 1'($urandom_range(0, 1));
        r.slot_in      = slot;
        pending_reqs.push_back(r);
        n_queued++;
    endtask

    task automatic queue_random(output logic counted);
        int         r;
        logic [2:0] slot;
        r       = $urandom_range(0, 99);
        slot    = 3'($urandom_range(0, 7));
        counted = 1'b1;
        if (r < 45)
            queue_get(unit_pool[$urandom_range(0, 3)], block_pool[$urandom_range(0, 3)],
                      $urandom_range(0, 3) == 0);
        else if (r < 50)
            queue_get(any_unit(), $urandom(), 1'($urandom_range(0, 1)));
        else if (r < 72)
            queue_op(FUNC_PUT, slot);
        else if (r < 85)
            queue_op(FUNC_DIRTY, slot);
        else if (r < 90)
            queue_op(FUNC_FAIL, slot);
        else if (r < 96)
            queue_op(FUNC_SYNC, slot);
        else begin
            queue_op(3'($urandom_range(FUNC_RSVD5, FUNC_RSVD7)), slot);
            counted = 1'b0;
        end
    endtask

    task automatic run_phase(input int n_items);
        logic counted;
        int   done;
        done = 0;
        for (int k = 0; k < 4; k++) begin
            unit_pool[k]  = any_unit();
            block_pool[k] = (k == 0) ? 32'hFFFF_FFFF : (k == 1) ? 32'd0 : $urandom();
        end
        while (done < n_items) begin
            queue_random(counted);
            if (counted)
                done++;
        end
        while (n_accepted != n_queued)
            @(posedge i_clk);
        while (expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_LOOP_BASE:    loop_first   = val;
            CFG_FLOPPY_UNITS: floppy_count = val;
            CFG_DISK_UNITS:   disk_count   = val;
            CFG_LOOP_UNITS:   loop_count   = val;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input logic [7:0] lb, input logic [7:0] fl,
                                 input logic [7:0] dk, input logic [7:0] lp);
        write_reg(CFG_LOOP_BASE, lb);
        write_reg(CFG_FLOPPY_UNITS, fl);
        write_reg(CFG_DISK_UNITS, dk);
        write_reg(CFG_LOOP_UNITS, lp);
        n_settings++;
    endtask

    initial begin
        loop_first   = RST_LOOP_BASE;
        floppy_count = RST_FLOPPY_UNITS;
        disk_count   = RST_DISK_UNITS;
        loop_count   = RST_LOOP_UNITS;
        search_start = 0;
        for (int k = 0; k < SLOTS; k++) begin
            line_unit[k]   = 8'd0;
            line_block[k]  = 32'd0;
            line_valid[k]  = 1'b0;
            line_pinned[k] = 1'b0;
            line_dirty[k]  = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: hit, miss, absent units, put errors, sync, eviction, full ring
        queue_get(8'd0, 32'd0, 1'b0);
        queue_get(8'd0, 32'd0, 1'b1);
        queue_get(8'd1, 32'hFFFF_FFFF, 1'b1);
        queue_get(8'd2, 32'd7, 1'b0);
        queue_get(8'h80, 32'd5, 1'b0);
        queue_get(8'h81, 32'd5, 1'b0);
        queue_get(8'hF0, 32'd5, 1'b0);
        queue_op(FUNC_DIRTY, 3'd0);
        queue_op(FUNC_DIRTY, 3'd7);
        queue_op(FUNC_PUT, 3'd0);
        queue_op(FUNC_PUT, 3'd0);
        queue_op(FUNC_SYNC, 3'd0);
        queue_op(FUNC_DIRTY, 3'd1);
        queue_op(FUNC_FAIL, 3'd1);
        queue_op(FUNC_FAIL, 3'd6);
        queue_op(FUNC_RSVD5, 3'd2);
        queue_op(FUNC_RSVD7, 3'd5);
        queue_op(FUNC_DIRTY, 3'd0);
        for (int k = 0; k < 8; k++)
            queue_get(8'd1, 32'h100 + k, k[0]);
        run_phase(25);

        apply_setting(8'd255, 8'd128, 8'd128, 8'd255);
        run_phase(25);
        apply_setting(8'd0, 8'd0, 8'd0, 8'd255);
        run_phase(30);
        apply_setting(8'hC0, 8'd4, 8'd0, 8'd8);
        run_phase(25);
        apply_setting(8'h80, 8'd1, 8'd128, 8'd0);
        run_phase(25);
        apply_setting(RST_LOOP_BASE, RST_FLOPPY_UNITS, RST_DISK_UNITS, 8'd16);
        run_phase(25);

        $display("summary: %0d requests under %0d register settings, %0d results checked",
                 n_accepted, n_settings, n_checked);
        $display("summary: %0d hits, %0d misses, %0d reads, %0d write-backs, %0d refused gets",
                 n_hits, n_misses, n_reads, n_wbacks, n_refused);
        if (n_errors == 0 && expected_replies.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
